### rtl/core/jac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jac_pkg
// Shared types and constants of the joystick axis conditioner: field types,
// operation and direction codes, scaling constants and the control bundle
// that the sequencer sends to each axis.
// ----------------------------------------------------------------------------
package jac_pkg;

  // Field types
  typedef logic [1:0]        op_t;
  typedef logic [7:0]        raw_t;
  typedef logic signed [7:0] pos_t;
  typedef logic [1:0]        dir_t;

  // Operation codes
  localparam op_t OP_READ       = 2'd0;
  localparam op_t OP_CAL_START  = 2'd1;
  localparam op_t OP_CAL_SAMPLE = 2'd2;

  // Direction codes
  localparam dir_t DIR_NEUTRAL = 2'd0;
  localparam dir_t DIR_ABOVE   = 2'd1;
  localparam dir_t DIR_BELOW   = 2'd2;

  // Scaling constants
  localparam raw_t FULL_SCALE  = 8'd100;
  localparam raw_t BAND_START  = 8'd127;
  localparam raw_t BAND_MARGIN = 8'd2;

  // Dividend width: 255 * 100 fits in 15 bits; one quotient bit per step
  localparam int DVD_W     = 15;
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Sequencer to axis control
  typedef struct packed {
    logic accept;  // transfer on the input channel
    logic load;    // form the dividend
    logic step;    // one divide step
  } ctrl_t;

endpackage : jac_pkg
`default_nettype wire

### rtl/core/jac_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jac_axis
// One joystick axis: running extremes, neutral band, classification of the
// sample against the band and a bit-serial restoring divider that scales the
// deflection to a percent of the tracked range.
// ----------------------------------------------------------------------------
module jac_axis (
  input  logic          clk,
  input  logic          rst_n,
  input  jac_pkg::ctrl_t ctrl,
  input  jac_pkg::op_t   op,
  input  jac_pkg::raw_t  raw,
  output jac_pkg::pos_t  position,
  output jac_pkg::dir_t  direction
);
  import jac_pkg::*;

  // State
  raw_t ext_hi_r, ext_hi_nxt, ext_lo_r, ext_lo_nxt;
  raw_t band_hi_r, band_hi_nxt, band_lo_r, band_lo_nxt;

  // Per-item working registers
  dir_t              dir_r, dir_nxt;
  logic              sat_r, sat_nxt;
  raw_t              num_r, num_nxt;
  raw_t              den_r, den_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  raw_t              rem_r, rem_nxt;

  // Combinational helpers
  logic [8:0]        center_sum;
  raw_t              center;
  raw_t              hi_upd, lo_upd;
  logic              is_meas, above, below;
  logic [DVD_W-1:0]  num_ext;
  logic [8:0]        rem_sh;
  logic              fits;
  logic [8:0]        rem_diff;
  logic              over;
  raw_t              mag;

  // Classify the sample against the band as it stands
  assign center_sum = {1'b0, band_hi_r} + {1'b0, band_lo_r};
  assign center     = center_sum[8:1];
  assign hi_upd     = (raw > ext_hi_r) ? raw : ext_hi_r;
  assign lo_upd     = (raw < ext_lo_r) ? raw : ext_lo_r;
  assign is_meas    = (op == OP_READ) || (op == OP_CAL_SAMPLE);
  assign above      = raw > band_hi_r;
  assign below      = raw < band_lo_r;

  // Divider datapath: num * 100 as shifts, one quotient bit per step
  assign num_ext  = {{(DVD_W-8){1'b0}}, num_r};
  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign fits     = rem_sh >= {1'b0, den_r};

  always_comb begin
    ext_hi_nxt  = ext_hi_r;
    ext_lo_nxt  = ext_lo_r;
    band_hi_nxt = band_hi_r;
    band_lo_nxt = band_lo_r;
    dir_nxt     = dir_r;
    sat_nxt     = sat_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    dvd_nxt     = dvd_r;
    rem_nxt     = rem_r;

    if (ctrl.accept) begin
      // Default: neutral result
      dir_nxt = DIR_NEUTRAL;
      sat_nxt = 1'b0;
      num_nxt = '0;
      den_nxt = 8'd1;
      if (is_meas) begin
        ext_hi_nxt = hi_upd;
        ext_lo_nxt = lo_upd;
        if (above) begin
          dir_nxt = DIR_ABOVE;
          sat_nxt = !((hi_upd > center) && (raw >= center));
          num_nxt = raw - center;
          den_nxt = hi_upd - center;
        end else if (below) begin
          dir_nxt = DIR_BELOW;
          sat_nxt = !((lo_upd < center) && (raw <= center));
          num_nxt = center - raw;
          den_nxt = center - lo_upd;
        end
        // Widen the band past the sample
        if (op == OP_CAL_SAMPLE) begin
          if (below) begin
            band_lo_nxt = (raw >= BAND_MARGIN) ? raw - BAND_MARGIN : 8'd0;
          end
          if (above) begin
            band_hi_nxt = (raw <= 8'd255 - BAND_MARGIN) ? raw + BAND_MARGIN : 8'd255;
          end
        end
      end else if (op == OP_CAL_START) begin
        band_hi_nxt = BAND_START;
        band_lo_nxt = BAND_START;
      end
    end

    if (ctrl.load) begin
      dvd_nxt = (num_ext << 6) + (num_ext << 5) + (num_ext << 2);
      rem_nxt = '0;
    end

    if (ctrl.step) begin
      rem_nxt = fits ? rem_diff[7:0] : rem_sh[7:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], fits};
    end
  end

  // Hold state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_hi_r  <= 8'd0;
      ext_lo_r  <= 8'd255;
      band_hi_r <= BAND_START;
      band_lo_r <= BAND_START;
    end else begin
      ext_hi_r  <= ext_hi_nxt;
      ext_lo_r  <= ext_lo_nxt;
      band_hi_r <= band_hi_nxt;
      band_lo_r <= band_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dir_r <= dir_nxt;
    sat_r <= sat_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  // Clamp the quotient and apply the sign
  assign over = sat_r || (dvd_r > {{(DVD_W-8){1'b0}}, FULL_SCALE});
  assign mag  = over ? FULL_SCALE : dvd_r[7:0];

  always_comb begin
    case (dir_r)
      DIR_ABOVE: position = pos_t'(mag);
      DIR_BELOW: position = pos_t'(8'd0 - mag);
      default:   position = '0;
    endcase
  end

  assign direction = dir_r;

endmodule : jac_axis
`default_nettype wire

### rtl/core/joystick_axis_conditioner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_axis_conditioner
// Two-axis joystick conditioning: extreme tracking, neutral band calibration
// and percent scaling with direction per axis.
// ----------------------------------------------------------------------------
// One item is in work at a time. After an input transfer the block forms the
// dividend, runs the bit-serial restoring divider of each axis (one quotient
// bit per cycle, both axes in parallel) and then loads the output register,
// which waits while the output side stalls; only then is a new item taken.
// The output register lets the next item be taken while a finished result
// still waits. Operation 1 restarts calibration (bands to 127), operation 2
// reads and then widens the bands by two past the sample; operation 3
// returns a neutral result.
// ----------------------------------------------------------------------------
module joystick_axis_conditioner (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  jac_pkg::op_t  in_operation,
  input  jac_pkg::raw_t in_x_raw,
  input  jac_pkg::raw_t in_y_raw,
  output logic          out_valid,
  input  logic          out_stall,
  output jac_pkg::pos_t out_x_position,
  output jac_pkg::pos_t out_y_position,
  output jac_pkg::dir_t out_x_direction,
  output jac_pkg::dir_t out_y_direction
);
  import jac_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  pos_t             out_x_pos_r, out_y_pos_r;
  dir_t             out_x_dir_r, out_y_dir_r;

  ctrl_t            ctrl;
  logic             in_xfer;
  logic             out_free;
  logic             out_load;
  pos_t             x_pos, y_pos;
  dir_t             x_dir, y_dir;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_OUT) && out_free;

  // Sequence: accept, load, divide, deliver
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ctrl.accept = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.step   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          ctrl.accept = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        ctrl.load = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        ctrl.step = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: load a finished result, drop valid after a transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_pos_r <= x_pos;
      out_y_pos_r <= y_pos;
      out_x_dir_r <= x_dir;
      out_y_dir_r <= y_dir;
    end
  end

  // Axes
  jac_axis u_axis_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .op        (in_operation),
    .raw       (in_x_raw),
    .position  (x_pos),
    .direction (x_dir)
  );

  jac_axis u_axis_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .op        (in_operation),
    .raw       (in_y_raw),
    .position  (y_pos),
    .direction (y_dir)
  );

  assign out_valid       = out_valid_r;
  assign out_x_position  = out_x_pos_r;
  assign out_y_position  = out_y_pos_r;
  assign out_x_direction = out_x_dir_r;
  assign out_y_direction = out_y_dir_r;

endmodule : joystick_axis_conditioner
`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Joystick axis conditioner testbench
// Sends a short table of hand-checked samples, then calibration sessions with
// random content, through the valid/stall input channel. Random gaps and
// stalls are applied on both channels, plus one long output hold-off. Each
// result is compared field by field against an in-bench model of extreme
// tracking, neutral bands and percent scaling.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jac_pkg::*;

  // Operation code that the block must answer with a neutral result
  localparam op_t OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    pos_t x_pos;
    pos_t y_pos;
    dir_t x_dir;
    dir_t y_dir;
  } result_t;

  typedef struct packed {
    op_t     op;
    raw_t    x;
    raw_t    y;
    logic    typed;  // expectation written out below, else predicted
    result_t want;
  } stim_row_t;

  localparam result_t NEUTRAL = '{8'sd0, 8'sd0, DIR_NEUTRAL, DIR_NEUTRAL};

  // Directed samples: reset state, full-scale deflection, the smallest
  // deflection that still reports a direction, the unused operation,
  // band widening with saturation at both rails, and a narrow calibration.
  localparam stim_row_t DIRECTED [25] = '{
    '{OP_READ,       8'd127, 8'd127, 1'b1, NEUTRAL},
    '{OP_READ,       8'd255, 8'd0,   1'b1, '{8'sd100, -8'sd100, DIR_ABOVE, DIR_BELOW}},
    '{OP_READ,       8'd0,   8'd255, 1'b1, '{-8'sd100, 8'sd100, DIR_BELOW, DIR_ABOVE}},
    '{OP_READ,       8'd128, 8'd126, 1'b1, '{8'sd0, 8'sd0, DIR_ABOVE, DIR_BELOW}},
    '{OP_READ,       8'd191, 8'd63,  1'b1, '{8'sd50, -8'sd50, DIR_ABOVE, DIR_BELOW}},
    '{OP_UNUSED,     8'd255, 8'd0,   1'b1, NEUTRAL},
    '{OP_CAL_SAMPLE, 8'd0,   8'd255, 1'b1, '{-8'sd100, 8'sd100, DIR_BELOW, DIR_ABOVE}},
    '{OP_CAL_SAMPLE, 8'd1,   8'd254, 1'b0, NEUTRAL},
    '{OP_CAL_START,  8'd200, 8'd50,  1'b1, NEUTRAL},
    '{OP_CAL_SAMPLE, 8'd1,   8'd254, 1'b0, NEUTRAL},
    '{OP_CAL_START,  8'd0,   8'd0,   1'b1, NEUTRAL},
    '{OP_CAL_SAMPLE, 8'd2,   8'd253, 1'b0, NEUTRAL},
    '{OP_CAL_SAMPLE, 8'd253, 8'd2,   1'b0, NEUTRAL},
    '{OP_READ,       8'd127, 8'd127, 1'b1, NEUTRAL},
    '{OP_READ,       8'd255, 8'd255, 1'b1, NEUTRAL},
    '{OP_CAL_START,  8'd255, 8'd255, 1'b1, NEUTRAL},
    '{OP_CAL_SAMPLE, 8'd120, 8'd135, 1'b0, NEUTRAL},
    '{OP_CAL_SAMPLE, 8'd140, 8'd110, 1'b0, NEUTRAL},
    '{OP_READ,       8'd130, 8'd130, 1'b0, NEUTRAL},
    '{OP_READ,       8'd117, 8'd143, 1'b0, NEUTRAL},
    '{OP_READ,       8'd200, 8'd40,  1'b0, NEUTRAL},
    '{OP_READ,       8'd50,  8'd220, 1'b0, NEUTRAL},
    '{OP_UNUSED,     8'd0,   8'd255, 1'b1, NEUTRAL},
    '{OP_READ,       8'd0,   8'd0,   1'b0, NEUTRAL},
    '{OP_READ,       8'd255, 8'd255, 1'b0, NEUTRAL}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  op_t  in_operation = OP_READ;
  raw_t in_x_raw = '0;
  raw_t in_y_raw = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pos_t out_x_position;
  pos_t out_y_position;
  dir_t out_x_direction;
  dir_t out_y_direction;

  // Axis 0 is X, axis 1 is Y
  raw_t seen_hi [2];
  raw_t seen_lo [2];
  raw_t band_hi [2];
  raw_t band_lo [2];

  result_t pending_results [$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      items_sent = 0;
  int      tx_mode = 1;  // 0: back-to-back, 1: random gaps
  int      rx_mode = 1;  // 0: never stall, 1: random stalls
  bit      hold_req = 1'b0;

  joystick_axis_conditioner u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_x_raw        (in_x_raw),
    .in_y_raw        (in_y_raw),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x_position  (out_x_position),
    .out_y_position  (out_y_position),
    .out_x_direction (out_x_direction),
    .out_y_direction (out_y_direction)
  );

  always #5 clk = ~clk;

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Scale one axis against its band center and tracked extreme
  function automatic void scale_axis(input raw_t raw, input raw_t ext_hi, input raw_t ext_lo,
                                     input raw_t b_hi, input raw_t b_lo,
                                     output pos_t pos, output dir_t dir);
    int center;
    int mag;
    int full;
    full   = int'(FULL_SCALE);
    center = (int'(b_hi) + int'(b_lo)) / 2;
    pos    = 8'sd0;
    dir    = DIR_NEUTRAL;
    if (raw > b_hi) begin
      if (int'(ext_hi) > center && int'(raw) >= center)
        mag = (int'(raw) - center) * full / (int'(ext_hi) - center);
      else
        mag = full;
      if (mag > full) mag = full;
      pos = pos_t'(mag);
      dir = DIR_ABOVE;
    end else if (raw < b_lo) begin
      if (int'(ext_lo) < center && int'(raw) <= center)
        mag = (center - int'(raw)) * full / (center - int'(ext_lo));
      else
        mag = full;
      if (mag > full) mag = full;
      pos = pos_t'(-mag);
      dir = DIR_BELOW;
    end
  endfunction

  // Advance the axis state by one sample and give the conditioned result
  task automatic condition_sample(input op_t op, input raw_t x, input raw_t y,
                                  output result_t res);
    raw_t raw [2];
    pos_t pos [2];
    dir_t dir [2];
    raw[0] = x;
    raw[1] = y;
    res = NEUTRAL;
    if (op == OP_READ || op == OP_CAL_SAMPLE) begin
      for (int a = 0; a < 2; a++) begin
        if (raw[a] > seen_hi[a]) seen_hi[a] = raw[a];
        if (raw[a] < seen_lo[a]) seen_lo[a] = raw[a];
        scale_axis(raw[a], seen_hi[a], seen_lo[a], band_hi[a], band_lo[a], pos[a], dir[a]);
        // widen the band past the sample, clamped to the rails
        if (op == OP_CAL_SAMPLE) begin
          if (raw[a] < band_lo[a])
            band_lo[a] = (raw[a] >= BAND_MARGIN) ? raw_t'(raw[a] - BAND_MARGIN) : 8'd0;
          if (raw[a] > band_hi[a])
            band_hi[a] = (raw[a] <= 8'd255 - BAND_MARGIN) ? raw_t'(raw[a] + BAND_MARGIN)
                                                          : 8'd255;
        end
      end
      res = '{pos[0], pos[1], dir[0], dir[1]};
    end else if (op == OP_CAL_START) begin
      for (int a = 0; a < 2; a++) begin
        band_hi[a] = BAND_START;
        band_lo[a] = BAND_START;
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (tx_mode == 0) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Half uniform, the rest weighted near the band and at both rails
  function automatic raw_t pick_raw();
    int r;
    r = $urandom_range(9);
    if (r < 5) return raw_t'($urandom_range(255));
    if (r < 8) return raw_t'($urandom_range(155, 100));
    if (r < 9) return raw_t'($urandom_range(5));
    return raw_t'($urandom_range(255, 250));
  endfunction

  // Offer one item, hold it until the transfer, then queue its expectation
  task automatic send_item(input op_t op, input raw_t x, input raw_t y,
                           input logic typed, input result_t want);
    int gap;
    result_t pred;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_x_raw     <= x;
    in_y_raw     <= y;
    do @(posedge clk); while (!(in_valid && !in_stall));
    condition_sample(op, x, y, pred);
    pending_results.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // Output side: random stalls, plus the long hold-off on request
  always @(negedge clk) begin : drive_stall
    int r;
    static int stall_left = 0;
    static int hold_left = 0;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (rx_mode == 0) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(99);
      if (r < 70) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = (r < 95) ? $urandom_range(2) : $urandom_range(39, 9);
        out_stall <= 1'b1;
      end
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_error("result transfer with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (out_x_position !== want.x_pos)
          report_error($sformatf("x_position got %0d want %0d",
                                 out_x_position, want.x_pos));
        if (out_y_position !== want.y_pos)
          report_error($sformatf("y_position got %0d want %0d",
                                 out_y_position, want.y_pos));
        if (out_x_direction !== want.x_dir)
          report_error($sformatf("x_direction got %0d want %0d",
                                 out_x_direction, want.x_dir));
        if (out_y_direction !== want.y_dir)
          report_error($sformatf("y_direction got %0d want %0d",
                                 out_y_direction, want.y_dir));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int session;
    int n_cal;
    int n_read;
    op_t op;
    session = 0;
    for (int a = 0; a < 2; a++) begin
      seen_hi[a] = 8'd0;
      seen_lo[a] = 8'd255;
      band_hi[a] = BAND_START;
      band_lo[a] = BAND_START;
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int i = 0; i < $size(DIRECTED); i++)
      send_item(DIRECTED[i].op, DIRECTED[i].x, DIRECTED[i].y,
                DIRECTED[i].typed, DIRECTED[i].want);

    // Calibration sessions with random content; some skip the start or the
    // samples, and stray unused operations are mixed into the reads
    while (items_sent < RANDOM_ITEMS) begin
      session++;
      tx_mode = ($urandom_range(3) == 0) ? 0 : 1;
      rx_mode = ($urandom_range(3) == 0) ? 0 : 1;
      if (session == 3) begin
        tx_mode  = 0;
        hold_req = 1'b1;
      end
      if ($urandom_range(4) != 0)
        send_item(OP_CAL_START, pick_raw(), pick_raw(), 1'b0, NEUTRAL);
      n_cal = $urandom_range(8);
      for (int i = 0; i < n_cal; i++)
        send_item(OP_CAL_SAMPLE, pick_raw(), pick_raw(), 1'b0, NEUTRAL);
      n_read = $urandom_range(20, 4);
      for (int i = 0; i < n_read; i++) begin
        op = ($urandom_range(19) == 0) ? OP_UNUSED : OP_READ;
        send_item(op, pick_raw(), pick_raw(), 1'b0, NEUTRAL);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
rtl/core/jac_pkg.sv
rtl/core/jac_axis.sv
rtl/core/joystick_axis_conditioner.sv
tb/testbench.sv
